### sv/bfre_pkg.sv
// ----------------------------------------------------------------------------
// bfre_pkg
// shared types, field widths, register codes and the cut pattern helper
// for the bitmap free-run extractor
// ----------------------------------------------------------------------------
package bfre_pkg;

	// parameter defaults
	localparam int UnitMaxDef  = 4;
	localparam int MaxWordsDef = 8;
	localparam int WordBitsDef = 64;

	// fixed field widths
	localparam int WordPortW = 64;
	localparam int CountW    = 4;
	localparam int LimitW    = 10;
	localparam int IdW       = 16;
	localparam int OffsetW   = 9;
	localparam int UnitsW    = 3;
	localparam int CfgDataW  = 16;
	localparam int CfgIdxW   = 2;

	// results per word and reset values
	localparam int MaxResults   = 32;
	localparam int ResCntW      = $clog2(MaxResults);
	localparam int WordCountRst = 8;
	localparam int BitLimitRst  = 512;

	// width of the alignment cut pattern (covers word bits plus any phase)
	localparam int PatW = 128;

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgWordCount  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgBitLimit   = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgChunkIndex = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgZoneIndex  = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// status of the find-first unit
	typedef struct packed {
		logic found;
		logic more;
	} pick_stat_t;

	// bit k set where k is a multiple of unit
	function automatic logic [PatW-1:0] cut_pattern(input int unit);
		int              c;
		logic [PatW-1:0] p;
		c = 0;
		p = '0;
		for (int k = 0; k < PatW; k++) begin
			p[k] = (c == 0);
			c++;
			if (c == unit) begin
				c = 0;
			end
		end
		return p;
	endfunction

endpackage

### sv/bitmap_free_run_extractor_core.sv
// ----------------------------------------------------------------------------
// bitmap_free_run_extractor_core
// a word is accepted in the idle state; its blocks then come one per cycle,
// while the output is not stalled, out of the shared find-first unit (at most
// 32 blocks per word); a word that yields no block leaves the sequencer idle;
// the accept registers the piece masks, and each block is then loaded into the
// output register; asynchronous active-low reset clears config to its reset values,
// the scan position and stop flag to zero, and empties the output register
// ----------------------------------------------------------------------------
module bitmap_free_run_extractor_core
	import bfre_pkg::*;
#(
	parameter int PIECE_MAX = UnitMaxDef,
	parameter int MAX_WORDS = MaxWordsDef,
	parameter int WORD_BITS = WordBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	// input request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WordPortW-1:0] bitmap_word,
	input  logic                 start_of_run,
	// result request channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OffsetW-1:0]   block_offset,
	output logic [UnitsW-1:0]    block_units,
	output logic [IdW-1:0]       chunk_out,
	output logic [IdW-1:0]       zone_out,
	output logic                 last_of_word
);

	// bit index within a word
	localparam int IW  = $clog2(WORD_BITS);
	// word position, holds up to MAX_WORDS
	localparam int PW  = $clog2(MAX_WORDS + 1);
	localparam int WCW = (PW > CountW) ? PW : CountW;
	// unit index arithmetic, wide enough for base plus a whole word and the limit
	localparam int CWR = $clog2(MAX_WORDS * WORD_BITS + WORD_BITS + 1);
	localparam int CW  = (CWR > LimitW + 1) ? CWR : LimitW + 1;
	// alignment phase of a word's first unit
	localparam int PHW = (PIECE_MAX > 1) ? $clog2(PIECE_MAX) : 1;
	localparam int WordStep = WORD_BITS % PIECE_MAX;
	localparam logic [PatW-1:0] CutPat = cut_pattern(PIECE_MAX);

	// configuration registers
	logic [CountW-1:0] word_count_q;
	logic [LimitW-1:0] bit_limit_q;
	logic [IdW-1:0]    chunk_q;
	logic [IdW-1:0]    zone_q;

	// scan state across words
	logic [PW-1:0]  pos_q;
	logic           stopped_q;
	logic [PHW-1:0] phase_q;

	// per-word sequencer
	state_t               state_q, state_d;
	logic [WORD_BITS-1:0] starts_q;
	logic [WORD_BITS-1:0] ends_q;
	logic [CW-1:0]        base_q;
	logic [ResCntW-1:0]   cnt_q;

	// output register
	logic               out_valid_q;
	logic [OffsetW-1:0] offset_q;
	logic [UnitsW-1:0]  units_q;
	logic               last_q;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= CountW'(WordCountRst);
			bit_limit_q  <= LimitW'(BitLimitRst);
			chunk_q      <= '0;
			zone_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgWordCount:  word_count_q <= cfg_data[CountW-1:0];
				CfgBitLimit:   bit_limit_q  <= cfg_data[LimitW-1:0];
				CfgChunkIndex: chunk_q      <= cfg_data[IdW-1:0];
				CfgZoneIndex:  zone_q       <= cfg_data[IdW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// word setup: restart, limits and piece masks for the incoming word
	// ------------------------------------------------------------------
	logic [PW-1:0]        pos_eff;
	logic                 stopped_eff;
	logic [PHW-1:0]       phase_eff;
	logic [WCW-1:0]       wc_ext;
	logic [WCW-1:0]       words;
	logic                 active;
	logic [CW-1:0]        base;
	logic [CW-1:0]        lim;
	logic [PatW-1:0]      cut_shift;
	logic [WORD_BITS-1:0] cut;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] starts_new;
	logic [WORD_BITS-1:0] ends_new;
	logic                 stop_next;
	logic [PHW:0]         phase_sum;
	logic [PHW-1:0]       phase_next;

	// a restart makes this word word zero
	assign pos_eff     = start_of_run ? '0 : pos_q;
	assign stopped_eff = start_of_run ? 1'b0 : stopped_q;
	assign phase_eff   = start_of_run ? '0 : phase_q;

	// word limit is word_count capped at MAX_WORDS
	assign wc_ext = WCW'(word_count_q);
	assign words  = (wc_ext > WCW'(MAX_WORDS)) ? WCW'(MAX_WORDS) : wc_ext;
	assign active = !stopped_eff && (WCW'(pos_eff) < words);

	assign base = CW'(pos_eff) * CW'(WORD_BITS);
	assign lim  = CW'(bit_limit_q);

	// alignment boundaries inside this word, from the constant pattern
	assign cut_shift = CutPat >> phase_eff;
	assign cut       = cut_shift[WORD_BITS-1:0];

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			free_bits[j] = !bitmap_word[j] && ((base + CW'(j)) < lim);
		end
	end

	// a piece starts at a free unit after a used one or on a boundary,
	// and ends at a free unit before a used one or before a boundary
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			if (j == 0) begin
				starts_new[j] = free_bits[j];
			end else begin
				starts_new[j] = free_bits[j] && (!free_bits[j-1] || cut[j]);
			end
			if (j == WORD_BITS - 1) begin
				ends_new[j] = free_bits[j];
			end else begin
				ends_new[j] = free_bits[j] && (!free_bits[j+1] || cut[j+1]);
			end
		end
	end

	// scan ends once this word reaches the bit limit or the word limit
	assign stop_next = ((base + CW'(WORD_BITS)) >= lim) || ((WCW'(pos_eff) + 1'b1) >= words);

	assign phase_sum  = (PHW+1)'(phase_eff) + (PHW+1)'(WordStep);
	assign phase_next = (phase_sum >= (PHW+1)'(PIECE_MAX)) ?
		PHW'(phase_sum - (PHW+1)'(PIECE_MAX)) : PHW'(phase_sum);

	// ------------------------------------------------------------------
	// find-first unit
	// ------------------------------------------------------------------
	logic [IW-1:0]        s_idx;
	logic [IW-1:0]        e_idx;
	logic [WORD_BITS-1:0] starts_rest;
	logic [WORD_BITS-1:0] ends_rest;
	pick_stat_t           pick_stat;

	bfre_pick #(
		.WORD_BITS (WORD_BITS),
		.IW        (IW)
	) u_pick (
		.starts      (starts_q),
		.ends        (ends_q),
		.start_idx   (s_idx),
		.end_idx     (e_idx),
		.starts_rest (starts_rest),
		.ends_rest   (ends_rest),
		.stat        (pick_stat)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	logic in_acc;
	logic out_free;
	logic load;
	logic last_piece;
	logic begin_word;

	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign last_piece = !pick_stat.more || (cnt_q == ResCntW'(MaxResults - 1));
	assign begin_word = in_acc && active && (starts_new != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (begin_word) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load && last_piece) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		load     = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EMIT: load     = out_free && pick_stat.found;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			stopped_q <= 1'b0;
			phase_q   <= '0;
		end else begin
			state_q <= state_d;
			// scan state moves on each accepted active word; a restart alone still clears it
			if (in_acc) begin
				if (active) begin
					pos_q     <= pos_eff + 1'b1;
					stopped_q <= stop_next;
					phase_q   <= phase_next;
				end else begin
					pos_q     <= pos_eff;
					stopped_q <= stopped_eff;
					phase_q   <= phase_eff;
				end
			end
		end
	end

	// piece masks, word base and result count
	always_ff @(posedge clk) begin
		if (begin_word) begin
			starts_q <= starts_new;
			ends_q   <= ends_new;
			base_q   <= base;
			cnt_q    <= '0;
		end else if (load) begin
			starts_q <= starts_rest;
			ends_q   <= ends_rest;
			cnt_q    <= cnt_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic [CW-1:0] offset_sum;
	logic [IW:0]   len_full;

	assign offset_sum = base_q + CW'(s_idx);
	assign len_full   = {1'b0, e_idx} - {1'b0, s_idx} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			offset_q <= offset_sum[OffsetW-1:0];
			units_q  <= len_full[UnitsW-1:0];
			last_q   <= last_piece;
		end
	end

	assign out_valid    = out_valid_q;
	assign block_offset = offset_q;
	assign block_units  = units_q;
	assign last_of_word = last_q;
	// ids must change only while idle (the block does not enforce this); the live registers then serve every request
	assign chunk_out    = chunk_q;
	assign zone_out     = zone_q;

endmodule

### sv/bfre_pick.sv
// ----------------------------------------------------------------------------
// bfre_pick
// find-first unit: takes the lowest pending piece start and piece end,
// returns their bit indexes and the masks with both removed
// ----------------------------------------------------------------------------
module bfre_pick
	import bfre_pkg::*;
#(
	parameter int WORD_BITS = WordBitsDef,
	parameter int IW        = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] starts,
	input  logic [WORD_BITS-1:0] ends,
	output logic [IW-1:0]        start_idx,
	output logic [IW-1:0]        end_idx,
	output logic [WORD_BITS-1:0] starts_rest,
	output logic [WORD_BITS-1:0] ends_rest,
	output pick_stat_t           stat
);

	logic [WORD_BITS-1:0] s_low;
	logic [WORD_BITS-1:0] e_low;

	// isolate lowest set bit
	assign s_low = starts & (~starts + WORD_BITS'(1));
	assign e_low = ends & (~ends + WORD_BITS'(1));

	assign starts_rest = starts & ~s_low;
	assign ends_rest   = ends & ~e_low;

	always_comb begin
		start_idx = '0;
		end_idx   = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (s_low[j]) begin
				start_idx = start_idx | IW'(j);
			end
			if (e_low[j]) begin
				end_idx = end_idx | IW'(j);
			end
		end
	end

	assign stat.found = (starts != '0);
	assign stat.more  = (starts_rest != '0);

endmodule

### sv/bfre_checker.sv
// ----------------------------------------------------------------------------
// bfre_checker
// port-level checks of the extractor's result sequencing, bound to the core
// ----------------------------------------------------------------------------
module bfre_checker
	import bfre_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [OffsetW-1:0] block_offset,
	input logic [UnitsW-1:0]  block_units,
	input logic               last_of_word
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_offset)
			&& $stable(block_units) && $stable(last_of_word))
		else $error("stalled result changed");

	// no new word taken while a word still has blocks to send
	a_no_accept_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_word |-> in_stall)
		else $error("input taken before word finished");

	// blocks of one word follow back to back
	a_next_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_word |=> out_valid)
		else $error("gap inside a word's blocks");

endmodule

bind bitmap_free_run_extractor_core bfre_checker u_bfre_checker (.*);
